// ----- rtl/bpa_pkg.sv -----
// Shared types, codes and defaults for the binary point aligned add/subtract block.
// No dependencies; the design files refer to it by scoped names and the test files import it.
`default_nettype none
package bpa_pkg;

	localparam int MANT_BITS_DEF = 64;
	localparam int PORT_MANT_W   = 64;
	localparam int EXPO_W        = 8;
	localparam int OP_W          = 2;
	localparam int STAT_W        = 2;

	localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB      = 2'd1;
	localparam logic [OP_W-1:0] OP_RESCALE  = 2'd2;
	localparam logic [OP_W-1:0] OP_MINIMIZE = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVF = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NEG = 2'd2;

	localparam logic [1:0] SH_LEFT  = 2'd0;
	localparam logic [1:0] SH_RIGHT = 2'd1;
	localparam logic [1:0] SH_MIN   = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [EXPO_W-1:0] cnt;
	} shift_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} shift_sts_t;

endpackage
`default_nettype wire

// ----- rtl/bpa_ifs.sv -----
// Valid/ready channel interfaces for operand requests and results.
// Depends on bpa_pkg for field widths.
`default_nettype none
interface bpa_req_if;
	logic                             valid;
	logic                             ready;
	logic [bpa_pkg::OP_W-1:0]         opcode;
	logic [bpa_pkg::PORT_MANT_W-1:0]  mant_a;
	logic [bpa_pkg::EXPO_W-1:0]       expo_a;
	logic [bpa_pkg::PORT_MANT_W-1:0]  mant_b;
	logic [bpa_pkg::EXPO_W-1:0]       expo_b;
	logic [bpa_pkg::EXPO_W-1:0]       target_expo;

	modport source (output valid, opcode, mant_a, expo_a, mant_b, expo_b, target_expo,
		input ready);
	modport sink (input valid, opcode, mant_a, expo_a, mant_b, expo_b, target_expo,
		output ready);
endinterface

interface bpa_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [bpa_pkg::PORT_MANT_W-1:0]  result_mant;
	logic [bpa_pkg::EXPO_W-1:0]       result_expo;
	logic [bpa_pkg::STAT_W-1:0]       status;

	modport source (output valid, result_mant, result_expo, status, input ready);
	modport sink (input valid, result_mant, result_expo, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/bpa_shift_unit.sv -----
// Single-step shifter shared by alignment, rescale and minimize.
// Depends on bpa_pkg for the control and status structs.
`default_nettype none
module bpa_shift_unit #(
	parameter int MANT_BITS = bpa_pkg::MANT_BITS_DEF
) (
	input  bpa_pkg::shift_ctl_t   ctl,
	input  logic [MANT_BITS-1:0]  m,
	output logic [MANT_BITS-1:0]  m_nxt,
	output bpa_pkg::shift_sts_t   sts
);

	logic cnt_zero;
	logic m_zero;
	logic top_full;

	assign cnt_zero = (ctl.cnt == '0);
	assign m_zero   = (m == '0);
	assign top_full = m[MANT_BITS-1] | m[MANT_BITS-2];

	always_comb begin
		m_nxt    = m;
		sts.done = 1'b1;
		sts.ovf  = 1'b0;
		case (ctl.mode)
			bpa_pkg::SH_LEFT: begin
				m_nxt    = m << 1;
				sts.done = cnt_zero | m_zero | top_full;
				sts.ovf  = !cnt_zero && !m_zero && top_full;
			end
			bpa_pkg::SH_RIGHT: begin
				m_nxt    = m >> 1;
				sts.done = cnt_zero | m_zero;
			end
			bpa_pkg::SH_MIN: begin
				m_nxt    = m >> 1;
				sts.done = cnt_zero | m[0];
			end
			default: begin
				m_nxt    = m;
				sts.done = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/bpa_alu.sv -----
// Final add, subtract or pass-through of operand a, and status selection on the aligned operands.
// Depends on bpa_pkg for opcode and status codes.
`default_nettype none
module bpa_alu #(
	parameter int MANT_BITS = bpa_pkg::MANT_BITS_DEF
) (
	input  logic [bpa_pkg::OP_W-1:0]    op,
	input  logic [MANT_BITS-1:0]        a,
	input  logic [MANT_BITS-1:0]        b,
	input  logic [bpa_pkg::EXPO_W-1:0]  expo,
	input  logic                        ovf,
	output logic [MANT_BITS-1:0]        res_mant,
	output logic [bpa_pkg::EXPO_W-1:0]  res_expo,
	output logic [bpa_pkg::STAT_W-1:0]  res_stat
);

	logic [MANT_BITS:0] sum;
	logic [MANT_BITS:0] diff;

	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};

	always_comb begin
		res_mant = '0;
		res_expo = '0;
		res_stat = bpa_pkg::STAT_OK;
		if (ovf) begin
			res_stat = bpa_pkg::STAT_OVF;
		end else begin
			case (op)
				bpa_pkg::OP_ADD: begin
					if (sum[MANT_BITS]) begin
						res_stat = bpa_pkg::STAT_OVF;
					end else begin
						res_mant = sum[MANT_BITS-1:0];
						res_expo = expo;
					end
				end
				bpa_pkg::OP_SUB: begin
					if (diff[MANT_BITS]) begin
						res_stat = bpa_pkg::STAT_NEG;
					end else begin
						res_mant = diff[MANT_BITS-1:0];
						res_expo = expo;
					end
				end
				default: begin
					res_mant = a;
					res_expo = expo;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/binary_point_aligned_add_sub.sv -----
// The request is registered, the shared shifter moves the operand one bit position per cycle
// until done, and the result is registered in the output register once that is free.
// One transaction at a time: req.ready is high only while the sequencer is idle, so a new
// transaction is taken only after the previous one has left the sequencer.
// A finished result waits in the output register while the next transaction is taken.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and empties the output.
`default_nettype none
module binary_point_aligned_add_sub #(
	parameter int MANT_BITS = bpa_pkg::MANT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	bpa_req_if.sink         req,
	bpa_rsp_if.source       rsp
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SHIFT  = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]                     state_q;
	logic [bpa_pkg::OP_W-1:0]       op_q;
	logic [MANT_BITS-1:0]           ma_q;
	logic [MANT_BITS-1:0]           mb_q;
	logic                           sel_b_q;
	logic [1:0]                     mode_q;
	logic [bpa_pkg::EXPO_W-1:0]     cnt_q;
	logic [bpa_pkg::EXPO_W-1:0]     exp_q;
	logic                           ovf_q;
	logic [MANT_BITS-1:0]           out_mant_q;
	logic [bpa_pkg::EXPO_W-1:0]     out_expo_q;
	logic [bpa_pkg::STAT_W-1:0]     out_stat_q;
	logic                           out_valid_q;

	logic [MANT_BITS-1:0]           in_ma;
	logic [MANT_BITS-1:0]           in_mb;
	logic                           accept;
	logic                           out_free;
	bpa_pkg::shift_ctl_t            sh_ctl;
	bpa_pkg::shift_sts_t            sh_sts;
	logic [MANT_BITS-1:0]           sh_m;
	logic [MANT_BITS-1:0]           sh_m_nxt;
	logic [MANT_BITS-1:0]           alu_mant;
	logic [bpa_pkg::EXPO_W-1:0]     alu_expo;
	logic [bpa_pkg::STAT_W-1:0]     alu_stat;

	assign in_ma    = req.mant_a[MANT_BITS-1:0];
	assign in_mb    = req.mant_b[MANT_BITS-1:0];
	assign req.ready = (state_q == S_IDLE);
	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign sh_ctl.mode = mode_q;
	assign sh_ctl.cnt  = cnt_q;
	assign sh_m        = sel_b_q ? mb_q : ma_q;

	bpa_shift_unit #(.MANT_BITS(MANT_BITS)) u_shift (
		.ctl   (sh_ctl),
		.m     (sh_m),
		.m_nxt (sh_m_nxt),
		.sts   (sh_sts)
	);

	bpa_alu #(.MANT_BITS(MANT_BITS)) u_alu (
		.op       (op_q),
		.a        (ma_q),
		.b        (mb_q),
		.expo     (exp_q),
		.ovf      (ovf_q),
		.res_mant (alu_mant),
		.res_expo (alu_expo),
		.res_stat (alu_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (sh_sts.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= req.opcode;
					ma_q  <= in_ma;
					mb_q  <= in_mb;
					ovf_q <= 1'b0;
					case (req.opcode)
						bpa_pkg::OP_ADD, bpa_pkg::OP_SUB: begin
							mode_q <= bpa_pkg::SH_LEFT;
							if (req.expo_a < req.expo_b) begin
								sel_b_q <= 1'b0;
								cnt_q   <= req.expo_b - req.expo_a;
								exp_q   <= req.expo_b;
							end else begin
								sel_b_q <= 1'b1;
								cnt_q   <= req.expo_a - req.expo_b;
								exp_q   <= req.expo_a;
							end
						end
						bpa_pkg::OP_RESCALE: begin
							sel_b_q <= 1'b0;
							exp_q   <= req.target_expo;
							if (req.target_expo > req.expo_a) begin
								mode_q <= bpa_pkg::SH_LEFT;
								cnt_q  <= req.target_expo - req.expo_a;
							end else begin
								mode_q <= bpa_pkg::SH_RIGHT;
								cnt_q  <= req.expo_a - req.target_expo;
							end
						end
						default: begin
							sel_b_q <= 1'b0;
							mode_q  <= bpa_pkg::SH_MIN;
							exp_q   <= req.expo_a;
							cnt_q   <= (in_ma == '0) ? '0 : req.expo_a;
						end
					endcase
				end
			end
			S_SHIFT: begin
				if (sh_sts.done) begin
					ovf_q <= sh_sts.ovf;
					if (mode_q == bpa_pkg::SH_MIN) begin
						exp_q <= cnt_q;
					end
				end else begin
					cnt_q <= cnt_q - bpa_pkg::EXPO_W'(1);
					if (sel_b_q) begin
						mb_q <= sh_m_nxt;
					end else begin
						ma_q <= sh_m_nxt;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					out_mant_q <= alu_mant;
					out_expo_q <= alu_expo;
					out_stat_q <= alu_stat;
				end
			end
			default: begin
				ovf_q <= 1'b0;
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_mant = bpa_pkg::PORT_MANT_W'(out_mant_q);
	assign rsp.result_expo = out_expo_q;
	assign rsp.status      = out_stat_q;

endmodule
`default_nettype wire

// ----- rtl/bpa_checker.sv -----
// Port-level checks on the binary point aligned add/subtract block, with its bind.
// Depends on bpa_pkg for status codes and on the top level's channel ports.
`default_nettype none
module bpa_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic                             req_ready,
	input  logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  logic [bpa_pkg::PORT_MANT_W-1:0]  rsp_mant,
	input  logic [bpa_pkg::EXPO_W-1:0]       rsp_expo,
	input  logic [bpa_pkg::STAT_W-1:0]       rsp_status
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("block ready right after taking a transaction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mant) && $stable(rsp_status))
		else $error("stalled result transaction changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == bpa_pkg::STAT_OK || rsp_status == bpa_pkg::STAT_OVF
		|| rsp_status == bpa_pkg::STAT_NEG))
		else $error("undefined status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == bpa_pkg::STAT_OVF || rsp_status == bpa_pkg::STAT_NEG)
		|-> rsp_mant == '0 && rsp_expo == '0)
		else $error("error result is not zero");

endmodule

bind binary_point_aligned_add_sub bpa_checker u_bpa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_mant   (rsp.result_mant),
	.rsp_expo   (rsp.result_expo),
	.rsp_status (rsp.status)
);
`default_nettype wire

// ----- test/binary_point_aligned_add_sub_checker.sv -----
`timescale 1ns / 1ps
// Checker for binary_point_aligned_add_sub: watches both channels and predicts each result.
// Compares every result transaction field by field with the oldest prediction.
// Depends on bpa_pkg and the channel interfaces in bpa_ifs.sv.
module binary_point_aligned_add_sub_checker (
	input  logic clk,
	input  logic arst_n,
	bpa_req_if   req,
	bpa_rsp_if   rsp,
	output int   fail_count,
	output int   outstanding
);
	import bpa_pkg::*;

	localparam int FIT_LIMIT  = MANT_BITS_DEF - 1;

	typedef struct packed {
		logic [PORT_MANT_W-1:0] mant;
		logic [EXPO_W-1:0]      expo;
		logic [STAT_W-1:0]      status;
	} tag_result_t;

	tag_result_t tag_results_due[$];

	function automatic int unsigned bit_length(input logic [PORT_MANT_W-1:0] v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < PORT_MANT_W; i++) begin
			if (v[i]) begin
				n = i + 1;
			end
		end
		return n;
	endfunction

	function automatic bit align_mant(input logic [PORT_MANT_W-1:0] m,
		input int unsigned src_expo, input int unsigned dst_expo,
		output logic [PORT_MANT_W-1:0] aligned);
		int unsigned d;
		aligned = '0;
		if (dst_expo == src_expo) begin
			aligned = m;
		end else if (dst_expo > src_expo) begin
			d = dst_expo - src_expo;
			if (m != '0 && bit_length(m) + d > FIT_LIMIT) begin
				return 1'b0;
			end
			aligned = (m == '0) ? '0 : (m << d);
		end else begin
			d = src_expo - dst_expo;
			aligned = (d >= PORT_MANT_W) ? '0 : (m >> d);
		end
		return 1'b1;
	endfunction

	function automatic tag_result_t predict_tag_op(input logic [OP_W-1:0] op,
		input logic [PORT_MANT_W-1:0] ma, input logic [EXPO_W-1:0] ea,
		input logic [PORT_MANT_W-1:0] mb, input logic [EXPO_W-1:0] eb,
		input logic [EXPO_W-1:0] tgt);
		tag_result_t r;
		logic [PORT_MANT_W-1:0] xa;
		logic [PORT_MANT_W-1:0] xb;
		logic [PORT_MANT_W:0]   sum;
		int unsigned e;
		r = '0;
		xa = '0;
		xb = '0;
		case (op)
		OP_ADD, OP_SUB: begin
			e = 32'((ea > eb) ? ea : eb);
			if (!align_mant(ma, 32'(ea), e, xa) || !align_mant(mb, 32'(eb), e, xb)) begin
				r.status = STAT_OVF;
			end else if (op == OP_ADD) begin
				sum = {1'b0, xa} + {1'b0, xb};
				if (sum[PORT_MANT_W]) begin
					r.status = STAT_OVF;
				end else begin
					r.mant = sum[PORT_MANT_W-1:0];
					r.expo = e[EXPO_W-1:0];
				end
			end else if (xa < xb) begin
				r.status = STAT_NEG;
			end else begin
				r.mant = xa - xb;
				r.expo = e[EXPO_W-1:0];
			end
		end
		OP_RESCALE: begin
			if (align_mant(ma, 32'(ea), 32'(tgt), xa)) begin
				r.mant = xa;
				r.expo = tgt;
			end else begin
				r.status = STAT_OVF;
			end
		end
		OP_MINIMIZE: begin
			r.mant = ma;
			e = 32'(ea);
			while (e > 0 && !r.mant[0]) begin
				r.mant = r.mant >> 1;
				e--;
			end
			r.expo = e[EXPO_W-1:0];
		end
		default: begin
			r = '0;
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [PORT_MANT_W-1:0] got,
		input logic [PORT_MANT_W-1:0] want);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		tag_result_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (tag_results_due.size() == 0) begin
					report_mismatch("result transaction with nothing expected",
						rsp.result_mant, '0);
				end else begin
					want = tag_results_due.pop_front();
					if (rsp.result_mant !== want.mant) begin
						report_mismatch("result_mant", rsp.result_mant, want.mant);
					end
					if (rsp.result_expo !== want.expo) begin
						report_mismatch("result_expo", PORT_MANT_W'(rsp.result_expo),
							PORT_MANT_W'(want.expo));
					end
					if (rsp.status !== want.status) begin
						report_mismatch("status", PORT_MANT_W'(rsp.status),
							PORT_MANT_W'(want.status));
					end
				end
			end
			if (req.valid && req.ready) begin
				tag_results_due.push_back(predict_tag_op(req.opcode, req.mant_a, req.expo_a,
					req.mant_b, req.expo_b, req.target_expo));
			end
			outstanding <= tag_results_due.size();
		end
	end

endmodule

// ----- test/binary_point_aligned_add_sub_test.sv -----
`timescale 1ns / 1ps
// Top of the testbench for binary_point_aligned_add_sub: clock, reset, request stimulus and result back-pressure.
// Checking is done by binary_point_aligned_add_sub_checker; this module gives the verdict.
// Depends on bpa_pkg, bpa_ifs.sv, the block and the checker.
module binary_point_aligned_add_sub_test;
	import bpa_pkg::*;

	localparam logic [PORT_MANT_W-1:0] ALL_ONES = '1;
	localparam logic [PORT_MANT_W-1:0] TOP_BIT  = {1'b1, {(PORT_MANT_W-1){1'b0}}};

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   sender_idle_pct;
	int   receiver_idle_pct;

	bpa_req_if req_ch ();
	bpa_rsp_if rsp_ch ();

	binary_point_aligned_add_sub DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	binary_point_aligned_add_sub_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	function automatic logic [PORT_MANT_W-1:0] random_mant();
		logic [PORT_MANT_W-1:0] v;
		int unsigned w;
		case ($urandom_range(7))
		0: return '0;
		1: return ALL_ONES;
		default: begin
			w = $urandom_range(1) ? $urandom_range(PORT_MANT_W) : $urandom_range(56, PORT_MANT_W);
			v = {$urandom, $urandom};
			if (w < PORT_MANT_W) begin
				v = v & ((64'd1 << w) - 64'd1);
			end
			if ($urandom_range(3) == 0) begin
				v = v << $urandom_range(40);
			end
			return v;
		end
		endcase
	endfunction

	function automatic logic [EXPO_W-1:0] near_expo(input logic [EXPO_W-1:0] base);
		int v;
		if ($urandom_range(3) == 0) begin
			return EXPO_W'($urandom_range(255));
		end
		v = int'(base) + int'($urandom_range(140)) - 70;
		if (v < 0) begin
			v = 0;
		end else if (v > 255) begin
			v = 255;
		end
		return v[EXPO_W-1:0];
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input logic [OP_W-1:0] op,
		input logic [PORT_MANT_W-1:0] ma, input logic [EXPO_W-1:0] ea,
		input logic [PORT_MANT_W-1:0] mb, input logic [EXPO_W-1:0] eb,
		input logic [EXPO_W-1:0] te);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.opcode      <= op;
		req_ch.mant_a      <= ma;
		req_ch.expo_a      <= ea;
		req_ch.mant_b      <= mb;
		req_ch.expo_b      <= eb;
		req_ch.target_expo <= te;
		req_ch.valid       <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		logic [OP_W-1:0]        op;
		logic [PORT_MANT_W-1:0] ma;
		logic [PORT_MANT_W-1:0] mb;
		logic [EXPO_W-1:0]      ea;
		logic [EXPO_W-1:0]      eb;
		logic [EXPO_W-1:0]      te;
		op = OP_W'($urandom_range(3));
		ma = random_mant();
		mb = random_mant();
		ea = EXPO_W'($urandom_range(255));
		eb = near_expo(ea);
		te = near_expo(ea);
		if ((op == OP_ADD || op == OP_SUB) && $urandom_range(3) == 0) begin
			eb = ea;
		end
		send_item(op, ma, ea, mb, eb, te);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_ADD;
		req_ch.mant_a      = '0;
		req_ch.expo_a      = '0;
		req_ch.mant_b      = '0;
		req_ch.expo_b      = '0;
		req_ch.target_expo = '0;
		rsp_ch.ready       = 1'b0;
		sender_idle_pct    = 9;
		receiver_idle_pct  = 56;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(OP_ADD, '0, 8'd0, '0, 8'd0, 8'd0);
		send_item(OP_ADD, ALL_ONES, 8'd7, '0, 8'd7, 8'd255);
		send_item(OP_ADD, ALL_ONES, 8'd7, 64'd1, 8'd7, 8'd0);
		send_item(OP_ADD, 64'd1, 8'd0, 64'd1, 8'd62, 8'd0);
		send_item(OP_ADD, 64'd1, 8'd0, 64'd1, 8'd63, 8'd0);
		send_item(OP_ADD, '0, 8'd0, ALL_ONES, 8'd255, 8'd0);
		send_item(OP_ADD, TOP_BIT, 8'd255, 64'd1, 8'd0, 8'd0);
		send_item(OP_ADD, ALL_ONES, 8'd200, 64'd5, 8'd200, 8'd0);
		send_item(OP_SUB, 64'd5, 8'd3, 64'd5, 8'd3, 8'd0);
		send_item(OP_SUB, 64'd4, 8'd3, 64'd5, 8'd3, 8'd0);
		send_item(OP_SUB, ALL_ONES, 8'd10, 64'd1, 8'd0, 8'd0);
		send_item(OP_SUB, 64'h4000_0000_0000_0000, 8'd0, '0, 8'd1, 8'd0);
		send_item(OP_RESCALE, 64'd123, 8'd9, ALL_ONES, 8'd255, 8'd9);
		send_item(OP_RESCALE, 64'h7FFF_FFFF_FFFF_FFFF, 8'd4, '0, 8'd0, 8'd5);
		send_item(OP_RESCALE, 64'h3FFF_FFFF_FFFF_FFFF, 8'd4, '0, 8'd0, 8'd5);
		send_item(OP_RESCALE, ALL_ONES, 8'd255, '0, 8'd0, 8'd0);
		send_item(OP_RESCALE, ALL_ONES, 8'd63, '0, 8'd0, 8'd0);
		send_item(OP_RESCALE, ALL_ONES, 8'd64, '0, 8'd0, 8'd0);
		send_item(OP_RESCALE, '0, 8'd0, '0, 8'd0, 8'd255);
		send_item(OP_MINIMIZE, 64'h10, 8'd0, ALL_ONES, 8'd255, 8'd255);
		send_item(OP_MINIMIZE, '0, 8'd200, '0, 8'd0, 8'd0);
		send_item(OP_MINIMIZE, TOP_BIT, 8'd255, '0, 8'd0, 8'd0);
		send_item(OP_MINIMIZE, 64'hF0, 8'd2, '0, 8'd0, 8'd0);
		send_item(OP_MINIMIZE, ALL_ONES, 8'd255, '0, 8'd0, 8'd0);

		// The sender holds off here until every result is back.
		drain_results();
		repeat (220) send_random_item();
		drain_results();

		sender_idle_pct   = 56;
		receiver_idle_pct = 9;
		repeat (220) send_random_item();
		drain_results();

		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		repeat (210) send_random_item();
		drain_results();
		repeat (MANT_BITS_DEF + 8) @(negedge clk);

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
